// File: rtl/ntc_pkg.sv
// Shared widths, register indexes, status codes, states and the thermistor curve ROM.
package ntc_pkg;

  localparam int ADC_W      = 16;
  localparam int OHM_W      = 20;
  localparam int BITS_W     = 6;
  localparam int TSTART_W   = 7;
  localparam int TEMP_W     = 13;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int TABLE_ENTRIES = 156;
  localparam int RES_FRAC_BITS = 8;
  localparam int ENTRY_W       = 18;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // Divider equation widths.
  localparam int DEN_W      = OHM_W + ADC_W;
  localparam int NUM_W      = 2 * OHM_W + ADC_W;
  localparam int DIV_W      = NUM_W + RES_FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int RESV_W     = ENTRY_W + RES_FRAC_BITS;
  localparam int HALF_OHM_W = OHM_W / 2;

  // Interpolation widths.
  localparam int SUM_W  = ((TSTART_W > IDX_W + 1) ? TSTART_W : IDX_W + 1) + 1;
  localparam int T0_W   = SUM_W + 4;
  localparam int DIFF_W = ENTRY_W + 1;
  localparam int TDEN_W = DIFF_W + RES_FRAC_BITS;
  localparam int ERR_W  = RESV_W + 1;
  localparam int E10_W  = ERR_W + 4;
  localparam int PROD_W = T0_W + TDEN_W;
  localparam int TNUM_W = PROD_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ADC_FULL_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_BITS            = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES_HIGH_OHMS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES_LOW_OHMS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_START_CELSIUS = 3'd4;

  localparam logic [ADC_W-1:0]           RST_ADC_FULL_SCALE      = 16'd4095;
  localparam logic [BITS_W-1:0]          RST_ADC_BITS            = 6'd12;
  localparam logic [OHM_W-1:0]           RST_SERIES_HIGH_OHMS    = 20'd390000;
  localparam logic [OHM_W-1:0]           RST_SERIES_LOW_OHMS     = 20'd3300;
  localparam logic signed [TSTART_W-1:0] RST_TABLE_START_CELSIUS = -7'sd30;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNSET = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OPEN  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_UP,
    S_MUL_LO,
    S_DEN,
    S_NUM_LO,
    S_NUM_HI,
    S_DIV_RES,
    S_WAIT_RES,
    S_LOAD,
    S_WALK,
    S_INT_DIFF,
    S_INT_MUL,
    S_INT_SUM,
    S_DIV_TEMP,
    S_WAIT_TEMP,
    S_EMIT
  } state_e;

  // Thermistor resistance in ohms at one-degree steps, falling with temperature.
  localparam logic [ENTRY_W-1:0] CURVE [TABLE_ENTRIES] = '{
    18'd177000, 18'd167680, 18'd158360, 18'd149040, 18'd139720, 18'd130400, 18'd123734,
    18'd117068, 18'd110402, 18'd103736, 18'd97070,  18'd92242,  18'd87414,  18'd82586,
    18'd77758,  18'd72930,  18'd69410,  18'd65890,  18'd62370,  18'd58850,  18'd55330,
    18'd52728,  18'd50126,  18'd47524,  18'd44922,  18'd42320,  18'd40388,  18'd38456,
    18'd36524,  18'd34592,  18'd32660,  18'd31206,  18'd29752,  18'd28298,  18'd26844,
    18'd25390,  18'd24292,  18'd23194,  18'd22096,  18'd20998,  18'd19900,  18'd19062,
    18'd18224,  18'd17386,  18'd16548,  18'd15710,  18'd15066,  18'd14422,  18'd13778,
    18'd13134,  18'd12490,  18'd11992,  18'd11494,  18'd10996,  18'd10498,  18'd10000,
    18'd9611,   18'd9223,   18'd8834,   18'd8446,   18'd8057,   18'd7752,   18'd7447,
    18'd7141,   18'd6836,   18'd6531,   18'd6290,   18'd6049,   18'd5809,   18'd5568,
    18'd5327,   18'd5135,   18'd4944,   18'd4752,   18'd4561,   18'd4369,   18'd4216,
    18'd4063,   18'd3909,   18'd3756,   18'd3603,   18'd3480,   18'd3356,   18'd3233,
    18'd3109,   18'd2986,   18'd2886,   18'd2787,   18'd2687,   18'd2588,   18'd2488,
    18'd2407,   18'd2326,   18'd2245,   18'd2164,   18'd2083,   18'd2017,   18'd1951,
    18'd1884,   18'd1818,   18'd1752,   18'd1698,   18'd1644,   18'd1589,   18'd1535,
    18'd1481,   18'd1436,   18'd1392,   18'd1347,   18'd1303,   18'd1258,   18'd1221,
    18'd1184,   18'd1146,   18'd1109,   18'd1072,   18'd1041,   18'd1010,   18'd979,
    18'd949,    18'd918,    18'd892,    18'd866,    18'd840,    18'd814,    18'd789,
    18'd767,    18'd745,    18'd723,    18'd702,    18'd680,    18'd662,    18'd643,
    18'd625,    18'd607,    18'd589,    18'd573,    18'd558,    18'd542,    18'd527,
    18'd511,    18'd498,    18'd485,    18'd472,    18'd459,    18'd445,    18'd434,
    18'd423,    18'd412,    18'd401,    18'd389,    18'd380,    18'd370,    18'd361,
    18'd351,    18'd342
  };

  localparam logic [ENTRY_W-1:0] CURVE_FIRST = CURVE[0];
  localparam logic [ENTRY_W-1:0] CURVE_LAST  = CURVE[TABLE_ENTRIES-1];

  function automatic logic [ENTRY_W-1:0] curve_rom(input logic [IDX_W-1:0] idx);
    logic [ENTRY_W-1:0] val;
    val = '0;
    if (int'(idx) < TABLE_ENTRIES) begin
      val = CURVE[idx];
    end
    return val;
  endfunction

endpackage

// File: rtl/ntc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by both divisions.
module ntc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ntc_pkg::DIV_W-1:0]      dividend_i,
  input  logic [ntc_pkg::DEN_W-1:0]      divisor_i,
  output logic                           done_o,
  output logic [ntc_pkg::DIV_W-1:0]      quotient_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [ntc_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [ntc_pkg::DEN_W-1:0]         rem_q;
  logic [ntc_pkg::DEN_W-1:0]         dsr_q;
  logic [ntc_pkg::DIV_W-1:0]         quo_q;
  logic [ntc_pkg::DEN_W:0]           rem_sh;
  logic [ntc_pkg::DEN_W:0]           rem_diff;
  logic                              fits;
  logic                              last_step;

  assign rem_sh    = {rem_q, quo_q[ntc_pkg::DIV_W-1]};
  assign rem_diff  = rem_sh - {1'b0, dsr_q};
  assign fits      = rem_sh >= {1'b0, dsr_q};
  assign last_step = cnt_q == ntc_pkg::DIV_CNT_W'(ntc_pkg::DIV_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[ntc_pkg::DIV_W-2:0], fits};
      rem_q <= fits ? rem_diff[ntc_pkg::DEN_W-1:0] : rem_sh[ntc_pkg::DEN_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/ntc_adc_to_temperature.sv
// NTC thermistor ADC sample to temperature converter, top level.
//
//   channel   signals                                     direction  request moves
//   ------------------------------------------------------------------------------------
//   input     in_valid_i / in_stall_o, adc_sample_i         in       one ADC sample
//   output    out_valid_o / out_stall_i,                    out      one temperature and
//             temperature_tenths_o, status_o                         status
//   config    cfg_valid_i / cfg_ready_o, cfg_index_i,       in       one register write
//             cfg_data_i
//
// One request is worked on at a time. The result goes to the output register after the
// check state for a zero sample, unset settings or a sample at or above full scale, after
// the denominator state when the divider denominator is not positive, and after the first
// division when the resistance lies outside the curve. A sample that reaches the
// interpolation takes two passes through the 64-step serial divider (one for a flat
// segment) and a walk of one table entry per cycle through the synchronous curve ROM (up to
// 155 entries). The next sample is accepted in the cycle after the result is loaded.
// Reset clears the state machine, the output valid and loads the register defaults; the
// curve ROM is constant and needs no clearing pass.
// A finished result waits in the output register while out_stall_i is high, and the next
// sample is already accepted; a further result waits in its final state until that
// register frees up.
//
// Resistance R = RB*RA*adc / (RA*(full-adc) - RB*adc) is formed in fixed point with
// RES_FRAC_BITS fraction bits by dividing the product shifted left by the fraction width.
// The segment with entry[i+1] < R <= entry[i] is then searched from the first entry, the
// cold end of the table, and the temperature is interpolated with a second, signed
// division that truncates toward zero.
module ntc_adc_to_temperature (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [ntc_pkg::ADC_W-1:0]             adc_sample_i,

  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [ntc_pkg::TEMP_W-1:0]     temperature_tenths_o,
  output logic [ntc_pkg::STATUS_W-1:0]          status_o,

  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ntc_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int F = ntc_pkg::RES_FRAC_BITS;

  ntc_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [ntc_pkg::ADC_W-1:0]             full_q;
  logic [ntc_pkg::BITS_W-1:0]            bits_q;
  logic [ntc_pkg::OHM_W-1:0]             ra_q;
  logic [ntc_pkg::OHM_W-1:0]             rb_q;
  logic signed [ntc_pkg::TSTART_W-1:0]   start_q;

  // Working registers of the request in flight.
  logic [ntc_pkg::ADC_W-1:0]             adc_q;
  logic [ntc_pkg::DEN_W-1:0]             upper_q;
  logic [ntc_pkg::DEN_W-1:0]             lower_q;
  logic [ntc_pkg::DEN_W-1:0]             den_q;
  logic [ntc_pkg::NUM_W-1:0]             num_q;
  logic [ntc_pkg::RESV_W-1:0]            res_q;
  logic [ntc_pkg::IDX_W-1:0]             idx_q;
  logic [ntc_pkg::ENTRY_W-1:0]           prev_q;
  logic [ntc_pkg::ENTRY_W-1:0]           hi_q;
  logic [ntc_pkg::ENTRY_W-1:0]           lo_q;
  logic [ntc_pkg::ENTRY_W-1:0]           rom_q;
  logic signed [ntc_pkg::DIFF_W-1:0]     diff_q;
  logic signed [ntc_pkg::T0_W-1:0]       t0_q;
  logic signed [ntc_pkg::ERR_W-1:0]      err_q;
  logic signed [ntc_pkg::TDEN_W-1:0]     tden_q;
  logic signed [ntc_pkg::PROD_W-1:0]     prod_q;
  logic signed [ntc_pkg::E10_W-1:0]      e10_q;
  logic signed [ntc_pkg::TNUM_W-1:0]     tnum_q;
  logic                                  neg_q;
  logic [ntc_pkg::TEMP_W-1:0]            res_temp_q;
  logic [ntc_pkg::STATUS_W-1:0]          res_status_q;

  logic                                  out_valid_q;
  logic [ntc_pkg::TEMP_W-1:0]            out_temp_q;
  logic [ntc_pkg::STATUS_W-1:0]          out_status_q;

  // Control from the output decode.
  logic                                  div_start;
  logic [ntc_pkg::DIV_W-1:0]             div_dividend;
  logic [ntc_pkg::DEN_W-1:0]             div_divisor;
  logic                                  div_done;
  logic [ntc_pkg::DIV_W-1:0]             div_quo;
  logic [ntc_pkg::IDX_W-1:0]             rom_addr;
  logic [ntc_pkg::OHM_W-1:0]             mul_a;
  logic [ntc_pkg::ADC_W-1:0]             mul_b;
  logic [ntc_pkg::HALF_OHM_W-1:0]        pp_b;

  // Datapath terms.
  logic                                  in_accept;
  logic                                  out_free;
  logic                                  adc_zero;
  logic                                  cfg_unset;
  logic                                  adc_over;
  logic                                  den_bad;
  logic                                  q_high;
  logic                                  q_low;
  logic                                  seg_hit;
  logic [ntc_pkg::DEN_W-1:0]             mul_p;
  logic [ntc_pkg::DEN_W+ntc_pkg::HALF_OHM_W-1:0] pp;
  logic signed [ntc_pkg::SUM_W-1:0]      seg_sum;
  logic signed [ntc_pkg::T0_W-1:0]       t0_c;
  logic signed [ntc_pkg::ERR_W-1:0]      err_c;
  logic signed [ntc_pkg::TDEN_W-1:0]     tden_c;
  logic [ntc_pkg::TNUM_W-1:0]            tnum_mag;
  logic [ntc_pkg::TDEN_W-1:0]            tden_mag;
  logic [ntc_pkg::TEMP_W-1:0]            quo_low;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign adc_zero  = adc_q == '0;
  assign cfg_unset = (full_q == '0) || (bits_q == '0);
  assign adc_over  = adc_q >= full_q;
  assign den_bad   = upper_q <= lower_q;

  // Integer part of the resistance against the ends of the curve.
  assign q_high = div_quo[ntc_pkg::DIV_W-1:F] > ntc_pkg::NUM_W'(ntc_pkg::CURVE_FIRST);
  assign q_low  = div_quo[ntc_pkg::DIV_W-1:F] < ntc_pkg::NUM_W'(ntc_pkg::CURVE_LAST);

  // prev_q holds entry[idx], the ROM output holds entry[idx+1]. The last segment is taken
  // when no earlier one matched.
  assign seg_hit = ((res_q > (ntc_pkg::RESV_W'(rom_q) << F)) &&
                    (res_q <= (ntc_pkg::RESV_W'(prev_q) << F))) ||
                   (idx_q == ntc_pkg::IDX_W'(ntc_pkg::TABLE_ENTRIES - 2));

  assign mul_p = ntc_pkg::DEN_W'(mul_a) * ntc_pkg::DEN_W'(mul_b);
  assign pp    = (ntc_pkg::DEN_W + ntc_pkg::HALF_OHM_W)'(lower_q) *
                 (ntc_pkg::DEN_W + ntc_pkg::HALF_OHM_W)'(pp_b);

  assign seg_sum = ntc_pkg::SUM_W'(start_q) + ntc_pkg::SUM_W'(signed'({1'b0, idx_q}));
  assign t0_c    = (ntc_pkg::T0_W'(seg_sum) <<< 3) + (ntc_pkg::T0_W'(seg_sum) <<< 1);
  assign err_c   = signed'(ntc_pkg::ERR_W'(ntc_pkg::RESV_W'(hi_q) << F)) -
                   signed'(ntc_pkg::ERR_W'(res_q));
  assign tden_c  = ntc_pkg::TDEN_W'(diff_q) <<< F;

  assign tnum_mag = tnum_q[ntc_pkg::TNUM_W-1] ? ntc_pkg::TNUM_W'(-tnum_q)
                                              : ntc_pkg::TNUM_W'(tnum_q);
  assign tden_mag = tden_q[ntc_pkg::TDEN_W-1] ? ntc_pkg::TDEN_W'(-tden_q)
                                              : ntc_pkg::TDEN_W'(tden_q);
  assign quo_low  = div_quo[ntc_pkg::TEMP_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ntc_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = ntc_pkg::S_CHECK;
        end
      end
      ntc_pkg::S_CHECK: begin
        if (adc_zero || cfg_unset || adc_over) begin
          state_d = ntc_pkg::S_EMIT;
        end else begin
          state_d = ntc_pkg::S_MUL_UP;
        end
      end
      ntc_pkg::S_MUL_UP: state_d = ntc_pkg::S_MUL_LO;
      ntc_pkg::S_MUL_LO: state_d = ntc_pkg::S_DEN;
      ntc_pkg::S_DEN: begin
        if (den_bad) begin
          state_d = ntc_pkg::S_EMIT;
        end else begin
          state_d = ntc_pkg::S_NUM_LO;
        end
      end
      ntc_pkg::S_NUM_LO:  state_d = ntc_pkg::S_NUM_HI;
      ntc_pkg::S_NUM_HI:  state_d = ntc_pkg::S_DIV_RES;
      ntc_pkg::S_DIV_RES: state_d = ntc_pkg::S_WAIT_RES;
      ntc_pkg::S_WAIT_RES: begin
        if (div_done) begin
          if (q_high || q_low) begin
            state_d = ntc_pkg::S_EMIT;
          end else begin
            state_d = ntc_pkg::S_LOAD;
          end
        end
      end
      ntc_pkg::S_LOAD: state_d = ntc_pkg::S_WALK;
      ntc_pkg::S_WALK: begin
        if (seg_hit) begin
          state_d = ntc_pkg::S_INT_DIFF;
        end
      end
      ntc_pkg::S_INT_DIFF: state_d = ntc_pkg::S_INT_MUL;
      ntc_pkg::S_INT_MUL: begin
        if (diff_q == '0) begin
          state_d = ntc_pkg::S_EMIT;
        end else begin
          state_d = ntc_pkg::S_INT_SUM;
        end
      end
      ntc_pkg::S_INT_SUM:  state_d = ntc_pkg::S_DIV_TEMP;
      ntc_pkg::S_DIV_TEMP: state_d = ntc_pkg::S_WAIT_TEMP;
      ntc_pkg::S_WAIT_TEMP: begin
        if (div_done) begin
          state_d = ntc_pkg::S_EMIT;
        end
      end
      ntc_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = ntc_pkg::S_IDLE;
        end
      end
      default: state_d = ntc_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall_o   = state_q != ntc_pkg::S_IDLE;
    div_start    = 1'b0;
    div_dividend = ntc_pkg::DIV_W'(num_q) << F;
    div_divisor  = den_q;
    rom_addr     = idx_q + ntc_pkg::IDX_W'(2);
    mul_a        = ra_q;
    mul_b        = full_q - adc_q;
    pp_b         = ra_q[ntc_pkg::HALF_OHM_W-1:0];
    case (state_q)
      ntc_pkg::S_MUL_LO: begin
        mul_a = rb_q;
        mul_b = adc_q;
      end
      ntc_pkg::S_NUM_HI: begin
        pp_b = ra_q[ntc_pkg::OHM_W-1:ntc_pkg::HALF_OHM_W];
      end
      ntc_pkg::S_DIV_RES: begin
        div_start = 1'b1;
      end
      ntc_pkg::S_WAIT_RES: begin
        rom_addr = '0;
      end
      ntc_pkg::S_LOAD: begin
        rom_addr = ntc_pkg::IDX_W'(1);
      end
      ntc_pkg::S_DIV_TEMP: begin
        div_start    = 1'b1;
        div_dividend = ntc_pkg::DIV_W'(tnum_mag);
        div_divisor  = ntc_pkg::DEN_W'(tden_mag);
      end
      default: begin
      end
    endcase
  end

  ntc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Synchronous curve ROM with a registered read output.
  always_ff @(posedge clk_i) begin
    rom_q <= ntc_pkg::curve_rom(rom_addr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ntc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      full_q      <= ntc_pkg::RST_ADC_FULL_SCALE;
      bits_q      <= ntc_pkg::RST_ADC_BITS;
      ra_q        <= ntc_pkg::RST_SERIES_HIGH_OHMS;
      rb_q        <= ntc_pkg::RST_SERIES_LOW_OHMS;
      start_q     <= ntc_pkg::RST_TABLE_START_CELSIUS;
    end else begin
      state_q <= state_d;
      if (state_q == ntc_pkg::S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ntc_pkg::REG_ADC_FULL_SCALE:   full_q <= cfg_data_i[ntc_pkg::ADC_W-1:0];
          ntc_pkg::REG_ADC_BITS:         bits_q <= cfg_data_i[ntc_pkg::BITS_W-1:0];
          ntc_pkg::REG_SERIES_HIGH_OHMS: ra_q   <= cfg_data_i[ntc_pkg::OHM_W-1:0];
          ntc_pkg::REG_SERIES_LOW_OHMS:  rb_q   <= cfg_data_i[ntc_pkg::OHM_W-1:0];
          ntc_pkg::REG_TABLE_START_CELSIUS: begin
            start_q <= signed'(cfg_data_i[ntc_pkg::TSTART_W-1:0]);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers of the request in flight.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ntc_pkg::S_IDLE: begin
        adc_q <= adc_sample_i;
      end
      ntc_pkg::S_CHECK: begin
        res_temp_q <= '0;
        if (adc_zero) begin
          res_status_q <= ntc_pkg::STATUS_SHORT;
        end else if (cfg_unset) begin
          res_status_q <= ntc_pkg::STATUS_UNSET;
        end else begin
          res_status_q <= ntc_pkg::STATUS_OPEN;
        end
      end
      ntc_pkg::S_MUL_UP: begin
        upper_q <= mul_p;
      end
      ntc_pkg::S_MUL_LO: begin
        lower_q <= mul_p;
      end
      ntc_pkg::S_DEN: begin
        den_q <= upper_q - lower_q;
      end
      ntc_pkg::S_NUM_LO: begin
        num_q <= ntc_pkg::NUM_W'(pp);
      end
      ntc_pkg::S_NUM_HI: begin
        num_q <= num_q + (ntc_pkg::NUM_W'(pp) << ntc_pkg::HALF_OHM_W);
      end
      ntc_pkg::S_WAIT_RES: begin
        res_q <= div_quo[ntc_pkg::RESV_W-1:0];
        idx_q <= '0;
        if (q_high) begin
          res_status_q <= ntc_pkg::STATUS_OPEN;
        end else begin
          res_status_q <= ntc_pkg::STATUS_SHORT;
        end
      end
      ntc_pkg::S_LOAD: begin
        prev_q <= rom_q;
      end
      ntc_pkg::S_WALK: begin
        if (seg_hit) begin
          hi_q <= prev_q;
          lo_q <= rom_q;
        end else begin
          prev_q <= rom_q;
          idx_q  <= idx_q + 1'b1;
        end
      end
      ntc_pkg::S_INT_DIFF: begin
        diff_q <= signed'({1'b0, hi_q}) - signed'({1'b0, lo_q});
        t0_q   <= t0_c;
        err_q  <= err_c;
      end
      ntc_pkg::S_INT_MUL: begin
        // A flat segment leaves the whole-degree value.
        res_temp_q   <= t0_q[ntc_pkg::TEMP_W-1:0];
        res_status_q <= ntc_pkg::STATUS_OK;
        tden_q       <= tden_c;
        prod_q       <= ntc_pkg::PROD_W'(t0_q) * ntc_pkg::PROD_W'(tden_c);
        e10_q        <= (ntc_pkg::E10_W'(err_q) <<< 3) + (ntc_pkg::E10_W'(err_q) <<< 1);
      end
      ntc_pkg::S_INT_SUM: begin
        tnum_q <= ntc_pkg::TNUM_W'(prod_q) + ntc_pkg::TNUM_W'(e10_q);
      end
      ntc_pkg::S_DIV_TEMP: begin
        neg_q <= tnum_q[ntc_pkg::TNUM_W-1] ^ tden_q[ntc_pkg::TDEN_W-1];
      end
      ntc_pkg::S_WAIT_TEMP: begin
        res_temp_q <= neg_q ? -quo_low : quo_low;
      end
      default: begin
      end
    endcase
    if (state_q == ntc_pkg::S_EMIT && out_free) begin
      out_temp_q   <= res_temp_q;
      out_status_q <= res_status_q;
    end
  end

  assign cfg_ready_o          = 1'b1;
  assign out_valid_o          = out_valid_q;
  assign temperature_tenths_o = signed'(out_temp_q);
  assign status_o             = out_status_q;

endmodule
